@@ rtl/tlaik_pkg.sv @@
// Shared types and constants of the two-link arm inverse kinematics core.
// Used by the front stage, the job queue, the square root and CORDIC units.
package tlaik_pkg;

   localparam int LEN_WIDTH       = 14;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int SQ_WIDTH        = 30;
   localparam int PROD_WIDTH      = 60;
   localparam int ROOT_WIDTH      = 30;
   localparam int REM_WIDTH       = 32;
   localparam int VEC_WIDTH       = 34;
   localparam int CORDIC_WIDTH    = 44;
   localparam int NORM_BITS       = 40;
   localparam int CORDIC_STEPS    = 32;
   localparam int NORM_STAGES     = 6;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UPPER_ARM = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FOREARM   = 2'd1;

   localparam logic [LEN_WIDTH-1:0] UPPER_ARM_RESET = 14'd2688;
   localparam logic [LEN_WIDTH-1:0] FOREARM_RESET   = 14'd3296;

   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] ZERO_TURN    = 32'h0000_0000;

   localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic                  reach;
      logic [SQ_WIDTH-1:0]   a;
      logic [SQ_WIDTH-1:0]   b;
      logic [30:0]           r2;
      logic signed [31:0]    l1x;
      logic signed [31:0]    l1y;
      logic [27:0]           l1sq;
      logic [27:0]           l2sq;
   } job_type;

endpackage

@@ rtl/two_link_arm_inverse_kinematics_core.sv @@
// Throughput: one target per cycle; the back pipeline never stalls, so busy stays low.
// Latency is mostly set by the 30-stage square root and the CORDIC lanes.
// Reset is synchronous, active high: clears valid bits and the queue, loads default lengths.
// Uses tlaik_pkg, tlaik_front, tlaik_queue, tlaik_sqrt and tlaik_cordic.
module two_link_arm_inverse_kinematics_core #(
   parameter int COORD_WIDTH = 16,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic signed [COORD_WIDTH-1:0]             req_target_x,
   input  logic signed [COORD_WIDTH-1:0]             req_target_y,
   output logic                                      rsp_valid,
   output logic signed [ANGLE_WIDTH-1:0]             rsp_shoulder_angle,
   output logic signed [ANGLE_WIDTH-1:0]             rsp_elbow_angle,
   output logic                                      rsp_reachable,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [tlaik_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [tlaik_pkg::LEN_WIDTH-1:0]           csr_data
);
   import tlaik_pkg::*;

   logic [LEN_WIDTH-1:0]    upper_ff, fore_ff;
   logic                    accept;
   logic                    job_valid;
   job_type                 job;
   job_type                 head;
   logic                    not_empty, full;

   logic                    b0_valid_ff;
   logic [PROD_WIDTH-1:0]   prod_ff;
   job_type                 b0_job_ff;

   logic                    sq_valid;
   logic [ROOT_WIDTH-1:0]   sq_root;
   job_type                 sq_job;

   logic                    b2_valid_ff;
   logic signed [VEC_WIDTH-1:0] num_ff, den_ff, s_ff, b_ff;
   logic [31:0]             el_zero_ff;
   logic                    reach_ff;
   logic signed [VEC_WIDTH-1:0] num_in, den_in;

   logic                    sh_valid, el_valid, sh_tag, el_tag, reach;
   logic [ANGLE_WIDTH-1:0]  sh_angle, el_angle;

   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign busy      = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= UPPER_ARM_RESET;
         fore_ff  <= FOREARM_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_UPPER_ARM: upper_ff <= csr_data;
            CSR_FOREARM:   fore_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   tlaik_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .target_x  (req_target_x),
      .target_y  (req_target_y),
      .upper_len (upper_ff),
      .fore_len  (fore_ff),
      .job_valid (job_valid),
      .job       (job)
   );

   tlaik_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_job  (job),
      .pop       (not_empty),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_valid_ff <= 1'b0;
      end else begin
         b0_valid_ff <= not_empty;
      end
      prod_ff   <= head.a * head.b;
      b0_job_ff <= head;
   end

   tlaik_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b0_valid_ff),
      .in_value  (prod_ff),
      .in_job    (b0_job_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_job   (sq_job)
   );

   always_comb begin
      num_in = (VEC_WIDTH'(sq_job.l1y) <<< 1) + signed'(VEC_WIDTH'(sq_root));
      den_in = signed'(VEC_WIDTH'(sq_job.l1sq)) - signed'(VEC_WIDTH'(sq_job.l2sq))
             + signed'(VEC_WIDTH'(sq_job.r2)) - (VEC_WIDTH'(sq_job.l1x) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff <= sq_valid;
      end
      num_ff     <= num_in;
      den_ff     <= den_in;
      s_ff       <= signed'(VEC_WIDTH'(sq_root));
      b_ff       <= signed'(VEC_WIDTH'(sq_job.b));
      el_zero_ff <= (sq_job.b == '0) ? QUARTER_TURN : ZERO_TURN;
      reach_ff   <= sq_job.reach;
   end

   tlaik_cordic #(
      .ANGLE_WIDTH(ANGLE_WIDTH)
   ) u_cordic_shoulder (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (b2_valid_ff),
      .in_y          (num_ff),
      .in_x          (den_ff),
      .in_zero_angle (ZERO_TURN),
      .in_tag        (reach_ff),
      .out_valid     (sh_valid),
      .out_angle     (sh_angle),
      .out_tag       (sh_tag)
   );

   tlaik_cordic #(
      .ANGLE_WIDTH(ANGLE_WIDTH)
   ) u_cordic_elbow (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (b2_valid_ff),
      .in_y          (s_ff),
      .in_x          (b_ff),
      .in_zero_angle (el_zero_ff),
      .in_tag        (reach_ff),
      .out_valid     (el_valid),
      .out_angle     (el_angle),
      .out_tag       (el_tag)
   );

   assign reach              = sh_tag && el_tag;
   assign rsp_valid          = sh_valid;
   assign rsp_reachable      = reach;
   assign rsp_shoulder_angle = reach ? signed'(sh_angle) : '0;
   assign rsp_elbow_angle    = reach ? signed'(el_angle) : '0;

`ifndef ASSERT_OFF
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (sh_valid == el_valid) && (!sh_valid || (sh_tag == el_tag)))
      else $error("shoulder and elbow lanes out of step");

   a_queue_drains: assert property (@(posedge clock) disable iff (reset)
      job_valid |=> !busy)
      else $error("job queue filled while back pipeline drains every cycle");

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_reachable) |-> ((rsp_shoulder_angle == '0) && (rsp_elbow_angle == '0)))
      else $error("unreachable result carries nonzero angles");
`endif

endmodule

@@ rtl/tlaik_front.sv @@
// Front stage: squares and products of the target and link lengths, reach check.
// Depends on tlaik_pkg for job_type and the length width.
module tlaik_front #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic signed [COORD_WIDTH-1:0]       target_x,
   input  logic signed [COORD_WIDTH-1:0]       target_y,
   input  logic [tlaik_pkg::LEN_WIDTH-1:0]     upper_len,
   input  logic [tlaik_pkg::LEN_WIDTH-1:0]     fore_len,
   output logic                                job_valid,
   output tlaik_pkg::job_type                  job
);
   import tlaik_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int RW = (2 * CW > 31) ? 2 * CW : 31;

   logic [CW-1:0]        ax, ay;
   logic [LEN_WIDTH-1:0] dm;
   logic [LEN_WIDTH:0]   sp;
   logic signed [16:0]   xt, yt;
   logic signed [14:0]   l1s;

   logic                 v1_ff;
   logic [2*CW-1:0]      xsq_ff, ysq_ff;
   logic [27:0]          dmsq_ff, l1sq_ff, l2sq_ff;
   logic [29:0]          spsq_ff;
   logic signed [31:0]   l1x_ff, l1y_ff;

   logic [RW-1:0]        r2;
   job_type              job_in;
   job_type              job_ff;
   logic                 job_valid_ff;

   assign ax  = target_x[CW-1] ? unsigned'(-target_x) : unsigned'(target_x);
   assign ay  = target_y[CW-1] ? unsigned'(-target_y) : unsigned'(target_y);
   assign dm  = (upper_len >= fore_len) ? upper_len - fore_len : fore_len - upper_len;
   assign sp  = {1'b0, upper_len} + {1'b0, fore_len};
   assign xt  = 17'(target_x);
   assign yt  = 17'(target_y);
   assign l1s = signed'({1'b0, upper_len});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      xsq_ff  <= ax * ax;
      ysq_ff  <= ay * ay;
      dmsq_ff <= dm * dm;
      spsq_ff <= sp * sp;
      l1sq_ff <= upper_len * upper_len;
      l2sq_ff <= fore_len * fore_len;
      l1x_ff  <= xt * l1s;
      l1y_ff  <= yt * l1s;
   end

   always_comb begin
      r2           = RW'(xsq_ff) + RW'(ysq_ff);
      job_in.reach = (r2 >= RW'(dmsq_ff)) && (r2 <= RW'(spsq_ff));
      job_in.a     = SQ_WIDTH'(r2 - RW'(dmsq_ff));
      job_in.b     = SQ_WIDTH'(RW'(spsq_ff) - r2);
      job_in.r2    = 31'(r2);
      job_in.l1x   = l1x_ff;
      job_in.l1y   = l1y_ff;
      job_in.l1sq  = l1sq_ff;
      job_in.l2sq  = l2sq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= v1_ff;
      end
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

@@ rtl/tlaik_queue.sv @@
// Two-entry job queue between the front stage and the back pipeline.
// Depends on tlaik_pkg for job_type.
module tlaik_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tlaik_pkg::job_type  push_job,
   input  logic                pop,
   output tlaik_pkg::job_type  head,
   output logic                not_empty,
   output logic                full
);
   import tlaik_pkg::*;

   job_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

@@ rtl/tlaik_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, job carried alongside.
// Depends on tlaik_pkg for job_type and the operand widths.
module tlaik_sqrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [tlaik_pkg::PROD_WIDTH-1:0]     in_value,
   input  tlaik_pkg::job_type                   in_job,
   output logic                                 out_valid,
   output logic [tlaik_pkg::ROOT_WIDTH-1:0]     out_root,
   output tlaik_pkg::job_type                   out_job
);
   import tlaik_pkg::*;

   localparam int NS = ROOT_WIDTH;

   logic [REM_WIDTH-1:0]  rem_ff  [NS];
   logic [ROOT_WIDTH-1:0] root_ff [NS];
   logic [PROD_WIDTH-1:0] val_ff  [NS];
   job_type               job_ff  [NS];
   logic [NS-1:0]         vld_ff;

   for (genvar k = 0; k < NS; k++) begin : g_stage
      logic [REM_WIDTH-1:0]   prev_rem;
      logic [ROOT_WIDTH-1:0]  prev_root;
      logic [PROD_WIDTH-1:0]  prev_val;
      job_type                prev_job;
      logic [REM_WIDTH+1:0]   rem_try;
      logic [REM_WIDTH+1:0]   trial;

      if (k == 0) begin : g_first
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_val  = in_value;
         assign prev_job  = in_job;
      end else begin : g_next
         assign prev_rem  = rem_ff[k-1];
         assign prev_root = root_ff[k-1];
         assign prev_val  = val_ff[k-1];
         assign prev_job  = job_ff[k-1];
      end

      assign rem_try = {prev_rem, prev_val[PROD_WIDTH-1 -: 2]};
      assign trial   = (REM_WIDTH+2)'({prev_root, 2'b01});

      always_ff @(posedge clock) begin
         if (rem_try >= trial) begin
            rem_ff[k]  <= REM_WIDTH'(rem_try - trial);
            root_ff[k] <= {prev_root[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_ff[k]  <= REM_WIDTH'(rem_try);
            root_ff[k] <= {prev_root[ROOT_WIDTH-2:0], 1'b0};
         end
         val_ff[k] <= {prev_val[PROD_WIDTH-3:0], 2'b00};
         job_ff[k] <= prev_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NS-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_job   = job_ff[NS-1];

endmodule

@@ rtl/tlaik_cordic.sv @@
// Pipelined vectoring CORDIC atan2 with normalizing shift stages and rounding.
// Depends on tlaik_pkg for widths, turn constants and the arctangent table.
module tlaik_cordic #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   input  logic signed [tlaik_pkg::VEC_WIDTH-1:0]  in_y,
   input  logic signed [tlaik_pkg::VEC_WIDTH-1:0]  in_x,
   input  logic [31:0]                             in_zero_angle,
   input  logic                                    in_tag,
   output logic                                    out_valid,
   output logic [ANGLE_WIDTH-1:0]                  out_angle,
   output logic                                    out_tag
);
   import tlaik_pkg::*;

   localparam int WW     = CORDIC_WIDTH;
   localparam int NS     = 1 + NORM_STAGES + CORDIC_STEPS;
   localparam int SH_OUT = 32 - ANGLE_WIDTH;

   typedef struct packed {
      logic signed [WW-1:0]  x;
      logic signed [WW-1:0]  y;
      logic [31:0]           z;
      logic [NORM_BITS-1:0]  m;
      logic                  zero;
      logic                  tag;
   } stage_type;

   stage_type               st_ff [NS];
   logic [NS-1:0]           vld_ff;
   stage_type               pre_in;
   logic signed [WW-1:0]    xe, ye, ay;
   logic                    neg;
   logic [31:0]             z2;
   logic [32:0]             rnd;
   logic                    out_valid_ff;
   logic [ANGLE_WIDTH-1:0]  out_angle_ff;
   logic                    out_tag_ff;

   always_comb begin
      xe          = WW'(in_x);
      ye          = WW'(in_y);
      neg         = in_x < 0;
      pre_in.x    = neg ? -xe : xe;
      pre_in.y    = neg ? -ye : ye;
      ay          = (pre_in.y < 0) ? -pre_in.y : pre_in.y;
      pre_in.m    = (pre_in.x > ay) ? NORM_BITS'(pre_in.x) : NORM_BITS'(ay);
      pre_in.zero = (in_x == 0) && (in_y == 0);
      pre_in.tag  = in_tag;
      if (pre_in.zero) begin
         pre_in.z = in_zero_angle;
      end else if (neg) begin
         pre_in.z = HALF_TURN;
      end else begin
         pre_in.z = ZERO_TURN;
      end
   end

   always_ff @(posedge clock) begin
      st_ff[0] <= pre_in;
   end

   for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
      localparam int SH = 32 >> k;
      stage_type nxt;

      always_comb begin
         nxt = st_ff[k];
         if (st_ff[k].m < (NORM_BITS'(1) << (NORM_BITS - SH))) begin
            nxt.x = st_ff[k].x <<< SH;
            nxt.y = st_ff[k].y <<< SH;
            nxt.m = st_ff[k].m << SH;
         end
      end

      always_ff @(posedge clock) begin
         st_ff[k+1] <= nxt;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      stage_type prv;
      stage_type nxt;

      assign prv = st_ff[NORM_STAGES+i];

      always_comb begin
         nxt = prv;
         if (!prv.zero) begin
            if (prv.y > 0) begin
               nxt.x = prv.x + (prv.y >>> i);
               nxt.y = prv.y - (prv.x >>> i);
               nxt.z = prv.z + ATAN_TABLE[i];
            end else begin
               nxt.x = prv.x - (prv.y >>> i);
               nxt.y = prv.y + (prv.x >>> i);
               nxt.z = prv.z - ATAN_TABLE[i];
            end
         end
      end

      always_ff @(posedge clock) begin
         st_ff[NORM_STAGES+1+i] <= nxt;
      end
   end

   assign z2  = {st_ff[NS-1].z[30:0], 1'b0};
   assign rnd = {1'b0, z2} + ((33'd1 << SH_OUT) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[NS-2:0], in_valid};
         out_valid_ff <= vld_ff[NS-1];
      end
      out_angle_ff <= rnd[31:SH_OUT];
      out_tag_ff   <= st_ff[NS-1].tag;
   end

   assign out_valid = out_valid_ff;
   assign out_angle = out_angle_ff;
   assign out_tag   = out_tag_ff;

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for two_link_arm_inverse_kinematics_core.
// Drives targets and link lengths, predicts joint angles with a local CORDIC model.
// Depends on tlaik_pkg and the core RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import tlaik_pkg::*;

   localparam int CW = 16;
   localparam int AW = 16;
   localparam int DRAIN_CYCLES = 100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 450;

   typedef struct packed {
      logic signed [AW-1:0] shoulder;
      logic signed [AW-1:0] elbow;
      logic                 reach;
   } angles_type;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 known;
      angles_type           want;
   } target_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CW-1:0] req_target_x = '0;
   logic signed [CW-1:0] req_target_y = '0;
   logic rsp_valid;
   logic signed [AW-1:0] rsp_shoulder_angle;
   logic signed [AW-1:0] rsp_elbow_angle;
   logic rsp_reachable;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [LEN_WIDTH-1:0] csr_data = '0;

   logic [LEN_WIDTH-1:0] upper_len;
   logic [LEN_WIDTH-1:0] fore_len;
   angles_type pending_angles[$];
   int failures = 0;
   int idle_cycles = 0;
   int targets_sent = 0;
   int angles_checked = 0;
   int reach_seen = 0;

   two_link_arm_inverse_kinematics_core #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) u_top (
      .clock, .reset, .start, .busy, .req_target_x, .req_target_y,
      .rsp_valid, .rsp_shoulder_angle, .rsp_elbow_angle, .rsp_reachable,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] cordic_angle(longint cy, longint cx);
      logic [31:0] z;
      longint m, dx, dy;
      z = '0;
      if (cx == 0 && cy == 0) return '0;
      if (cx < 0) begin
         cx = -cx;
         cy = -cy;
         z = HALF_TURN;
      end
      m = (cx > (cy < 0 ? -cy : cy)) ? cx : (cy < 0 ? -cy : cy);
      while (m < (64'sd1 <<< 39)) begin
         cx = cx * 2;
         cy = cy * 2;
         m = m * 2;
      end
      for (int i = 0; i < 32; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cy > 0) begin
            cx = cx + dx;
            cy = cy - dy;
            z = z + ATAN_TABLE[i];
         end else begin
            cx = cx - dx;
            cy = cy + dy;
            z = z - ATAN_TABLE[i];
         end
      end
      return z;
   endfunction

   function automatic logic [AW-1:0] turn_to_angle(logic [31:0] z);
      logic [32:0] z2;
      z2 = {1'b0, z[30:0], 1'b0} + (33'd1 << (32 - AW - 1));
      return z2[31:32-AW];
   endfunction

   function automatic longint root_floor(longint v);
      longint lo, hi, mid;
      lo = 0;
      hi = 64'd3037000499;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic angles_type solve_joints(logic signed [CW-1:0] tx,
                                               logic signed [CW-1:0] ty);
      angles_type res;
      longint x, y, l1, l2, r2, dm, sp, a, b, s, num, den;
      x = tx;
      y = ty;
      l1 = upper_len;
      l2 = fore_len;
      r2 = x * x + y * y;
      dm = (l1 > l2) ? l1 - l2 : l2 - l1;
      sp = l1 + l2;
      res = '0;
      if (r2 < dm * dm || r2 > sp * sp) return res;
      a = r2 - dm * dm;
      b = sp * sp - r2;
      s = root_floor(a * b);
      num = 2 * l1 * y + s;
      den = l1 * l1 - 2 * l1 * x - l2 * l2 + r2;
      res.shoulder = turn_to_angle(cordic_angle(num, den));
      res.elbow = (b == 0) ? turn_to_angle(QUARTER_TURN) : turn_to_angle(cordic_angle(s, b));
      res.reach = 1'b1;
      return res;
   endfunction

   task automatic finish_run(input bit timed_out);
      $display("Covered %0d targets, %0d results checked, %0d reachable.",
               targets_sent, angles_checked, reach_seen);
      if (!timed_out && failures == 0) begin
         $display("two_link_arm_inverse_kinematics_core regression: pass");
      end else begin
         $display("two_link_arm_inverse_kinematics_core regression: fail");
      end
      $finish;
   endtask

   always @(posedge clock) begin
      angles_type exp_a;
      if (!reset) begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("watchdog: no transaction for %0d cycles", idle_cycles);
            finish_run(1'b1);
         end
         if (rsp_valid) begin
            if (pending_angles.size() == 0) begin
               $error("result with no transaction outstanding");
               failures++;
            end else begin
               exp_a = pending_angles.pop_front();
               angles_checked++;
               if (rsp_reachable) reach_seen++;
               if (rsp_shoulder_angle !== exp_a.shoulder) begin
                  $error("shoulder_angle expected %0d actual %0d", exp_a.shoulder,
                         rsp_shoulder_angle);
                  failures++;
               end
               if (rsp_elbow_angle !== exp_a.elbow) begin
                  $error("elbow_angle expected %0d actual %0d", exp_a.elbow, rsp_elbow_angle);
                  failures++;
               end
               if (rsp_reachable !== exp_a.reach) begin
                  $error("reachable expected %0d actual %0d", exp_a.reach, rsp_reachable);
                  failures++;
               end
            end
         end
      end
   end

   task automatic send_target(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                              input bit known, input angles_type want);
      angles_type got;
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_target_x <= x;
      req_target_y <= y;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      got = solve_joints(x, y);
      if (known && got != want) begin
         $error("table row (%0d,%0d) expected %h predictor %h", x, y, want, got);
         failures++;
      end
      pending_angles.push_back(known ? want : got);
      targets_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (pending_angles.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_length(input logic [CSR_INDEX_WIDTH-1:0] idx,
                               input logic [LEN_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      if (idx == CSR_UPPER_ARM) upper_len = val;
      else fore_len = val;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic random_batch(input int n);
      logic signed [CW-1:0] x, y;
      int reach, ang;
      angles_type none;
      none = '0;
      reach = int'(upper_len) + int'(fore_len);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0 || reach == 0) begin
            x = CW'($urandom);
            y = CW'($urandom);
         end else begin
            ang = int'($urandom_range(0, reach));
            x = CW'($urandom_range(0, ang));
            y = CW'($urandom_range(0, ang));
            if ($urandom_range(0, 1)) x = -x;
            if ($urandom_range(0, 1)) y = -y;
            if (ang > 4) begin
               x = $urandom_range(0, 1) ? CW'(ang) : CW'(-ang);
               y = CW'(int'($urandom_range(0, ang / 3)) - ang / 6);
            end
         end
         send_target(x, y, 1'b0, none);
      end
   endtask

   target_row_type directed_rows[$];

   initial begin
      angles_type none;
      angles_type straight;
      none = '0;
      upper_len = UPPER_ARM_RESET;
      fore_len = FOREARM_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      straight = '{shoulder: '0, elbow: 16'sh8000, reach: 1'b1};
      directed_rows = '{
         '{16'sd0, 16'sd0, 1'b1, none},
         '{16'sh7FFF, 16'sh7FFF, 1'b1, none},
         '{-16'sh8000, -16'sh8000, 1'b1, none},
         '{-16'sh8000, 16'sh7FFF, 1'b1, none},
         '{16'sd5984, 16'sd0, 1'b1, straight},
         '{16'sd5985, 16'sd0, 1'b1, none},
         '{16'sd608, 16'sd0, 1'b0, none},
         '{16'sd607, 16'sd0, 1'b1, none},
         '{16'sd0, 16'sd5984, 1'b0, none},
         '{-16'sd5984, 16'sd0, 1'b0, none},
         '{16'sd0, -16'sd608, 1'b0, none},
         '{16'sd3000, 16'sd3000, 1'b0, none},
         '{-16'sd2000, 16'sd1500, 1'b0, none},
         '{16'sd1000, -16'sd4000, 1'b0, none}
      };
      foreach (directed_rows[i])
         send_target(directed_rows[i].x, directed_rows[i].y, directed_rows[i].known,
                     directed_rows[i].want);
      drain_results();
      write_length(CSR_UPPER_ARM, 14'd1000);
      write_length(CSR_FOREARM, 14'd1000);
      send_target(16'sd0, 16'sd0, 1'b0, none);
      send_target(16'sd2000, 16'sd0, 1'b0, none);
      send_target(16'sd0, -16'sd2000, 1'b0, none);
      random_batch(90);
      drain_results();
      write_length(CSR_UPPER_ARM, 14'd0);
      write_length(CSR_FOREARM, 14'd16383);
      send_target(16'sd0, 16'sd16383, 1'b0, none);
      random_batch(80);
      drain_results();
      write_length(CSR_UPPER_ARM, 14'd16383);
      write_length(CSR_FOREARM, 14'd0);
      random_batch(60);
      drain_results();
      write_length(CSR_UPPER_ARM, 14'd16383);
      write_length(CSR_FOREARM, 14'd16383);
      random_batch(60);
      drain_results();
      write_length(CSR_UPPER_ARM, 14'd0);
      write_length(CSR_FOREARM, 14'd0);
      send_target(16'sd0, 16'sd0, 1'b0, none);
      random_batch(10);
      drain_results();
      write_length(CSR_UPPER_ARM, UPPER_ARM_RESET);
      write_length(CSR_FOREARM, FOREARM_RESET);
      random_batch(RANDOM_ITEMS - 300);
      drain_results();
      finish_run(1'b0);
   end
endmodule

@@ filelist.f @@
rtl/tlaik_pkg.sv
rtl/tlaik_front.sv
rtl/tlaik_queue.sv
rtl/tlaik_sqrt.sv
rtl/tlaik_cordic.sv
rtl/two_link_arm_inverse_kinematics_core.sv
test/tb_top.sv
